[sv/uer_pkg.sv]
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// phase codes, status codes, register indexes, reset values, config struct
// no dependencies

package uer_pkg;

  localparam int COUNT_BITS = 16;
  localparam int WAIT_BITS  = 24;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 24;
  localparam int STATUS_BITS   = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [WAIT_BITS-1:0]  WAIT_MAX  = {WAIT_BITS{1'b1}};

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_GOOD     = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_NOTREADY = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_TICKS    = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POST_DELAY_TICKS = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_THRESHOLD   = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WAIT_LIMIT       = 4'd3;

  // register reset values
  localparam logic [COUNT_BITS-1:0] RST_TRIGGER_TICKS    = 16'd20;
  localparam logic [COUNT_BITS-1:0] RST_POST_DELAY_TICKS = 16'd20000;
  localparam logic [COUNT_BITS-1:0] RST_NEAR_THRESHOLD   = 16'd0;
  localparam logic [WAIT_BITS-1:0]  RST_WAIT_LIMIT       = 24'hFFFFFF;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_TRIG = 5'b00010,
    PH_RISE = 5'b00100,
    PH_MEAS = 5'b01000,
    PH_POST = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] trigger_ticks;
    logic [COUNT_BITS-1:0] post_delay_ticks;
    logic [COUNT_BITS-1:0] near_threshold;
    logic [WAIT_BITS-1:0]  wait_limit;
  } cfg_t;

endpackage

[sv/uer_if.sv]
// uer_if: handshake channels of the ultrasonic echo ranger
// input item, result item and register write channels; uses uer_pkg

interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;
  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_out_if;
  logic valid;
  logic ready;
  logic trigger_pin;
  logic busy_res;
  logic done_res;
  logic [uer_pkg::STATUS_BITS-1:0] status;
  logic [uer_pkg::COUNT_BITS-1:0]  echo_width;
  logic object_near;
  modport source (output valid, output trigger_pin, output busy_res, output done_res,
                  output status, output echo_width, output object_near, input ready);
  modport sink   (input valid, input trigger_pin, input busy_res, input done_res,
                  input status, input echo_width, input object_near, output ready);
endinterface

interface uer_cfg_if;
  logic valid;
  logic ready;
  logic [uer_pkg::CFG_IDX_BITS-1:0]  index;
  logic [uer_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/ultrasonic_echo_ranger_unit.sv]
// ultrasonic_echo_ranger_unit: top level of the ultrasonic echo ranger
// sequencer and result register; uses uer_pkg, uer_if and uer_cfg

// Each input item is one prescaled timer tick and yields exactly one result
// item describing the state after that tick. One item is taken every clock
// cycle while the output register is empty or being read; its result is
// registered there and the next item is taken in the same cycle that result
// is read. A start request runs trigger, wait for echo rise, echo measurement
// and post delay; done_res pulses with status good, timeout (echo count
// overflow) or not ready (wait limit). The user must write registers through
// the config channel only while no tick is in flight; this is not enforced.

module ultrasonic_echo_ranger_unit (
  input  logic       clk,
  input  logic       rst,
  uer_in_if.sink     item_in,
  uer_out_if.source  res_out,
  uer_cfg_if.sink    cfg
);

  uer_pkg::cfg_t regs;

  uer_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  uer_pkg::phase_t phase, phase_next;
  logic [uer_pkg::COUNT_BITS-1:0] tick_count, tick_count_next;
  logic [uer_pkg::WAIT_BITS-1:0]  wait_count, wait_count_next;
  logic [uer_pkg::COUNT_BITS-1:0] captured_width, captured_width_next;
  logic                           last_echo_level;
  logic                           done_next, near_next;
  logic [uer_pkg::STATUS_BITS-1:0] status_next;

  logic [uer_pkg::COUNT_BITS-1:0] trig_len, post_len, tick_inc;
  logic [uer_pkg::WAIT_BITS-1:0]  wait_inc;
  logic                           accept;

  assign item_in.ready = !res_out.valid || res_out.ready;
  assign accept        = item_in.valid && item_in.ready;

  // zero lengths act like one
  assign trig_len = (regs.trigger_ticks == '0) ?
                    uer_pkg::COUNT_BITS'(1) : regs.trigger_ticks;
  assign post_len = (regs.post_delay_ticks == '0) ?
                    uer_pkg::COUNT_BITS'(1) : regs.post_delay_ticks;
  assign tick_inc = (tick_count == uer_pkg::COUNT_MAX) ? tick_count : tick_count + 1'b1;
  assign wait_inc = (wait_count == uer_pkg::WAIT_MAX) ? wait_count : wait_count + 1'b1;

  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    wait_count_next     = wait_count;
    captured_width_next = captured_width;
    done_next           = 1'b0;
    near_next           = 1'b0;
    status_next         = uer_pkg::ST_GOOD;
    if (phase == uer_pkg::PH_IDLE) begin
      if (item_in.start_req) begin
        phase_next      = uer_pkg::PH_TRIG;
        tick_count_next = '0;
        wait_count_next = '0;
      end
    end else if (wait_inc >= regs.wait_limit) begin
      // wait limit is checked ahead of the phase work
      phase_next          = uer_pkg::PH_IDLE;
      tick_count_next     = '0;
      wait_count_next     = '0;
      captured_width_next = '0;
      done_next           = 1'b1;
      status_next         = uer_pkg::ST_NOTREADY;
    end else begin
      wait_count_next = wait_inc;
      unique case (phase)
        uer_pkg::PH_TRIG: begin
          tick_count_next = tick_inc;
          if (tick_inc >= trig_len) begin
            phase_next      = uer_pkg::PH_RISE;
            tick_count_next = '0;
          end
        end
        uer_pkg::PH_RISE: begin
          if (item_in.echo_level && !last_echo_level) begin
            phase_next      = uer_pkg::PH_MEAS;
            tick_count_next = uer_pkg::COUNT_BITS'(1);
          end
        end
        uer_pkg::PH_MEAS: begin
          if (item_in.echo_level) begin
            if (tick_count == uer_pkg::COUNT_MAX) begin
              phase_next          = uer_pkg::PH_IDLE;
              tick_count_next     = '0;
              wait_count_next     = '0;
              captured_width_next = '0;
              done_next           = 1'b1;
              status_next         = uer_pkg::ST_TIMEOUT;
            end else begin
              tick_count_next = tick_count + 1'b1;
            end
          end else begin
            captured_width_next = tick_count;
            phase_next          = uer_pkg::PH_POST;
            tick_count_next     = '0;
          end
        end
        uer_pkg::PH_POST: begin
          tick_count_next = tick_inc;
          if (tick_inc >= post_len) begin
            phase_next      = uer_pkg::PH_IDLE;
            tick_count_next = '0;
            wait_count_next = '0;
            done_next       = 1'b1;
            near_next       = captured_width < regs.near_threshold;
          end
        end
        default: begin
          phase_next          = uer_pkg::PH_IDLE;
          tick_count_next     = '0;
          wait_count_next     = '0;
          captured_width_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= uer_pkg::PH_IDLE;
      tick_count      <= '0;
      wait_count      <= '0;
      captured_width  <= '0;
      last_echo_level <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      wait_count      <= wait_count_next;
      captured_width  <= captured_width_next;
      last_echo_level <= item_in.echo_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (accept) begin
      res_out.valid <= 1'b1;
    end else if (res_out.ready) begin
      res_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_out.trigger_pin <= phase_next == uer_pkg::PH_TRIG;
      res_out.busy_res    <= phase_next != uer_pkg::PH_IDLE;
      res_out.done_res    <= done_next;
      res_out.status      <= status_next;
      res_out.echo_width  <= captured_width_next;
      res_out.object_near <= near_next;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.done_res |-> !res_out.busy_res)
    else $error("done reported while still busy");

  a_near_good: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.object_near |->
      res_out.done_res && res_out.status == uer_pkg::ST_GOOD)
    else $error("object_near without a good done");

  a_abort_clears: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.status != uer_pkg::ST_GOOD |->
      res_out.done_res && res_out.echo_width == '0)
    else $error("abort left a width or status without done");

  a_item_result: assert property (@(posedge clk) disable iff (rst)
    item_in.valid && item_in.ready |=> res_out.valid)
    else $error("accepted item produced no result");

endmodule

[sv/uer_cfg.sv]
// uer_cfg: configuration register file of the ultrasonic echo ranger
// takes writes from the register channel; uses uer_pkg and uer_cfg_if

module uer_cfg (
  input  logic          clk,
  input  logic          rst,
  uer_cfg_if.sink       cfg,
  output uer_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.trigger_ticks    <= uer_pkg::RST_TRIGGER_TICKS;
      regs.post_delay_ticks <= uer_pkg::RST_POST_DELAY_TICKS;
      regs.near_threshold   <= uer_pkg::RST_NEAR_THRESHOLD;
      regs.wait_limit       <= uer_pkg::RST_WAIT_LIMIT;
    end else if (cfg.valid) begin
      // indexes past the list are dropped
      case (cfg.index)
        uer_pkg::CFG_TRIGGER_TICKS:
          regs.trigger_ticks <= cfg.data[uer_pkg::COUNT_BITS-1:0];
        uer_pkg::CFG_POST_DELAY_TICKS:
          regs.post_delay_ticks <= cfg.data[uer_pkg::COUNT_BITS-1:0];
        uer_pkg::CFG_NEAR_THRESHOLD:
          regs.near_threshold <= cfg.data[uer_pkg::COUNT_BITS-1:0];
        uer_pkg::CFG_WAIT_LIMIT:
          regs.wait_limit <= cfg.data[uer_pkg::WAIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
